// ===== rtl/crc32_byte_stream_assert.svh =====
// Assertion macros shared by the CRC-32 byte stream checkers.
`ifndef CRC32_BYTE_STREAM_ASSERT_SVH
`define CRC32_BYTE_STREAM_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define CRC32BS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("crc32_byte_stream: assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define CRC32BS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("crc32_byte_stream: assertion failed");

`endif

// ===== rtl/crc32bs_pkg.sv =====
// Package: CRC-32 constants, stream item type and byte fold function.
`default_nettype none

package crc32bs_pkg;

  localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;

  // One input transaction payload
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  // Fold one byte into a reflected CRC-32, eight shift/XOR steps
  function automatic logic [31:0] fold_byte(input logic [31:0] crc_in,
                                            input logic [7:0]  data_in);
    logic [31:0] crc;
    crc = crc_in ^ {24'h00_0000, data_in};
    for (int k = 0; k < 8; k++) begin
      crc = {1'b0, crc[31:1]} ^ (CRC_POLY & {32{crc[0]}});
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/crc32bs_in_if.sv =====
// Interface: input byte stream channel (valid/ready plus byte and last flag).
`default_nettype none

interface crc32bs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/crc32bs_out_if.sv =====
// Interface: result channel carrying the final CRC value.
`default_nettype none

interface crc32bs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] crc_value;

  modport source (output valid, output crc_value, input ready);
  modport sink   (input valid, input crc_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/crc32bs_in_reg.sv =====
// Input register: captures one transaction and holds it until the core takes it.
`default_nettype none

module crc32bs_in_reg
  import crc32bs_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  output logic       ready_o,
  input  wire item_t item_i,
  input  wire logic  take_i,
  output logic       valid_o,
  output item_t      item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  // Register is free when empty or being drained this cycle
  assign ready_o = !valid_q || take_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ===== rtl/crc32bs_core.sv =====
// CRC core: running CRC register and zero-byte flag, updated once per byte.
`default_nettype none

module crc32bs_core
  import crc32bs_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  fire_i,
  input  wire item_t item_i,
  output logic [31:0] crc_value_o
);

  logic [31:0] crc_q, crc_d, crc_upd;
  logic        zero_seen_q, zero_seen_d;

  // Fold the byte unless the message already hit a zero byte
  always_comb begin
    crc_upd     = crc_q;
    zero_seen_d = zero_seen_q;
    if (!zero_seen_q) begin
      if (item_i.data_byte == 8'h00) begin
        zero_seen_d = 1'b1;
      end else begin
        crc_upd = fold_byte(crc_q, item_i.data_byte);
      end
    end
    crc_d = crc_upd;
    // End of message: restart from preset
    if (item_i.last_byte) begin
      crc_d       = CRC_PRESET;
      zero_seen_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= CRC_PRESET;
      zero_seen_q <= 1'b0;
    end else if (fire_i) begin
      crc_q       <= crc_d;
      zero_seen_q <= zero_seen_d;
    end
  end

  // Final value, valid when the last byte fires
  assign crc_value_o = ~crc_upd;

endmodule

`default_nettype wire

// ===== rtl/crc32bs_out_reg.sv =====
// Output register: holds the finished CRC until the sink takes it.
`default_nettype none

module crc32bs_out_reg (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire logic [31:0] crc_value_i,
  output logic             free_o,
  output logic             valid_o,
  input  wire logic        ready_i,
  output logic [31:0]      crc_value_o
);

  logic        valid_q, valid_d;
  logic [31:0] crc_q;

  // Slot can take a new result when empty or emptied this cycle
  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i ? 1'b1 : (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      crc_q <= crc_value_i;
    end
  end

  assign valid_o     = valid_q;
  assign crc_value_o = crc_q;

endmodule

`default_nettype wire

// ===== rtl/crc32_byte_stream.sv =====
// Top level: reflected CRC-32 over a byte stream, one byte per transaction.
// Each byte transaction enters an input register, is folded into the running
// CRC-32 (polynomial 0xEDB88320, preset all ones) by combinational logic, and
// the inverted CRC of the message lands in an output register when the byte
// flagged last is processed. The first zero byte of a message ends
// accumulation; it and later bytes of that message leave the CRC unchanged.
// Throughput is one byte per clock unless the input stalls. The output register
// loads when the last byte fires from the input register.
// Input stalls only while a finished result waits in the output register and
// the next processed byte is also a last byte.
`default_nettype none

module crc32_byte_stream
  import crc32bs_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  crc32bs_in_if.sink    in_i,
  crc32bs_out_if.source out_o
);

  item_t       in_item, reg_item;
  logic        reg_valid, fire, out_free;
  logic [31:0] crc_result;

  assign in_item.data_byte = in_i.data_byte;
  assign in_item.last_byte = in_i.last_byte;

  // A byte fires when its result, if any, has a place to go
  assign fire = reg_valid && (!reg_item.last_byte || out_free);

  crc32bs_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .item_i  (in_item),
    .take_i  (fire),
    .valid_o (reg_valid),
    .item_o  (reg_item)
  );

  crc32bs_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (reg_item),
    .crc_value_o (crc_result)
  );

  crc32bs_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire && reg_item.last_byte),
    .crc_value_i (crc_result),
    .free_o      (out_free),
    .valid_o     (out_o.valid),
    .ready_i     (out_o.ready),
    .crc_value_o (out_o.crc_value)
  );

endmodule

`default_nettype wire

// ===== rtl/crc32bs_checker.sv =====
// Checker: port-level assertions for the CRC-32 byte stream, with its bind.
`default_nettype none

`include "crc32_byte_stream_assert.svh"

module crc32bs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        in_last_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] out_crc_i
);

  // Stalled result stays offered
  `CRC32BS_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)

  // Stalled result keeps its value
  `CRC32BS_ASSERT_NXT(a_out_stable, out_valid_i && !out_ready_i, $stable(out_crc_i))

  // Input backpressure only comes from a blocked result
  `CRC32BS_ASSERT_IMP(a_stall_cause, !in_ready_i, out_valid_i && !out_ready_i)

  // A new result follows an accepted last-byte transaction
  `CRC32BS_ASSERT_IMP(a_out_origin, $rose(out_valid_i),
                      $past(in_valid_i && in_ready_i && in_last_i, 2))

endmodule

bind crc32_byte_stream crc32bs_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last_byte),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_crc_i   (out_o.crc_value)
);

`default_nettype wire
